// File: hw/rtl/skv_pkg.sv
package skv_pkg;

    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 32;

    localparam int KEY_W     = 64;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 3;
    localparam int RANK_W    = 7;
    localparam int IN_VAL_W  = 32;
    localparam int OUT_VAL_W = 32;
    localparam int CNT_OUT_W = 7;
    localparam int POS_W     = RANK_W + CNT_W + IDX_W;

    // slave-side beat layout
    localparam int S_CMD_LSB  = 0;
    localparam int S_KEY_LSB  = S_CMD_LSB + CMD_W;
    localparam int S_VAL_LSB  = S_KEY_LSB + KEY_W;
    localparam int S_RANK_LSB = S_VAL_LSB + IN_VAL_W;
    localparam int S_USED_W   = S_RANK_LSB + RANK_W;
    localparam int S_DATA_W   = ((S_USED_W + 7) / 8) * 8;

    // master-side beat layout
    localparam int M_STAT_LSB  = 0;
    localparam int M_VOUT_LSB  = M_STAT_LSB + STAT_W;
    localparam int M_CNT_LSB   = M_VOUT_LSB + OUT_VAL_W;
    localparam int M_DVLD_LSB  = M_CNT_LSB + CNT_OUT_W;
    localparam int M_DVAL_LSB  = M_DVLD_LSB + 1;
    localparam int M_USED_W    = M_DVAL_LSB + OUT_VAL_W;
    localparam int M_DATA_W    = ((M_USED_W + 7) / 8) * 8;

    localparam logic [KEY_W-1:0] KEY_RESERVED = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_LOOKUP = 3'd2,
        CMD_RANK   = 3'd3,
        CMD_PEEK   = 3'd4,
        CMD_POP    = 3'd5
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_KEY   = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_EMPTY     = 3'd5,
        ST_RANK_OOR  = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        FSM_IDLE = 3'b001,
        FSM_CMP  = 3'b010,
        FSM_EXE  = 3'b100
    } t_fsm;

    typedef struct packed {
        logic                  occ;
        logic                  lt;
        logic [KEY_W-1:0]      key;
        logic [VALUE_BITS-1:0] value;
    } t_slot_ent;

    typedef struct packed {
        logic                  compare;
        logic                  insert;
        logic                  remove;
        logic                  shift_all;
        logic [CMD_W-1:0]      cmd;
        logic [KEY_W-1:0]      key;
        logic [VALUE_BITS-1:0] value;
        logic [RANK_W-1:0]     rank;
    } t_slot_ctl;

endpackage

// File: hw/rtl/skv_slot.sv
module skv_slot (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [skv_pkg::IDX_W-1:0]         i_idx,
    input  skv_pkg::t_slot_ctl                i_ctl,
    input  skv_pkg::t_slot_ent                i_left,
    input  skv_pkg::t_slot_ent                i_right,
    output skv_pkg::t_slot_ent                o_ent,
    output logic                              o_eq,
    output logic [skv_pkg::VALUE_BITS-1:0]    o_sel_val
);

    logic                           r_occ, n_occ;
    logic                           r_lt, n_lt;
    logic                           r_eq, n_eq;
    logic                           r_sel, n_sel;
    logic [skv_pkg::KEY_W-1:0]      r_key, n_key;
    logic [skv_pkg::VALUE_BITS-1:0] r_val, n_val;
    logic                           w_pos_hit;
    logic                           w_head;

    assign w_pos_hit = (skv_pkg::POS_W'(i_idx) == skv_pkg::POS_W'(i_ctl.rank));
    assign w_head    = (i_idx == '0);

    always_comb begin
        n_occ = r_occ;
        n_lt  = r_lt;
        n_eq  = r_eq;
        n_sel = r_sel;
        n_key = r_key;
        n_val = r_val;
        if (i_ctl.compare) begin
            n_lt = r_occ & (r_key < i_ctl.key);
            n_eq = r_occ & (r_key == i_ctl.key);
            case (i_ctl.cmd)
                skv_pkg::CMD_REMOVE, skv_pkg::CMD_LOOKUP: begin
                    n_sel = r_occ & (r_key == i_ctl.key);
                end
                skv_pkg::CMD_RANK: begin
                    n_sel = r_occ & w_pos_hit;
                end
                skv_pkg::CMD_PEEK, skv_pkg::CMD_POP: begin
                    n_sel = r_occ & w_head;
                end
                default: begin
                    n_sel = 1'b0;
                end
            endcase
        end
        // open a gap at the insert point, everything above moves up one
        if (i_ctl.insert && !r_lt) begin
            if (i_left.lt) begin
                n_occ = 1'b1;
                n_key = i_ctl.key;
                n_val = i_ctl.value;
            end else begin
                n_occ = i_left.occ;
                n_key = i_left.key;
                n_val = i_left.value;
            end
        end
        // close the gap, everything from the removed slot up moves down one
        if (i_ctl.remove && (i_ctl.shift_all || !r_lt)) begin
            n_occ = i_right.occ;
            n_key = i_right.key;
            n_val = i_right.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
            r_lt  <= 1'b0;
            r_eq  <= 1'b0;
            r_sel <= 1'b0;
        end else begin
            r_occ <= n_occ;
            r_lt  <= n_lt;
            r_eq  <= n_eq;
            r_sel <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_val <= n_val;
    end

    assign o_ent.occ   = r_occ;
    assign o_ent.lt    = r_lt;
    assign o_ent.key   = r_key;
    assign o_ent.value = r_val;
    assign o_eq        = r_eq;
    assign o_sel_val   = r_sel ? r_val : '0;

endmodule

// File: hw/rtl/sorted_key_value_store.sv
// an accepted beat runs a compare pass then a shift pass; its result beat is registered as the shift pass finishes
// a new command is accepted only while idle or as the shift pass of the previous command finishes
// a result waiting on the master side holds the next command in its shift pass and stalls input
// reset: synchronous active-low, empties the store and clears discard reporting
// no clearing pass is needed after reset, occupancy lives in per-slot flip-flops
module sorted_key_value_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_data,      // discard_enable
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [skv_pkg::S_DATA_W-1:0]  s_axis_tdata,    // cmd, key, value, rank
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [skv_pkg::M_DATA_W-1:0]  m_axis_tdata     // status, value_out,
                                                           // entry_count, discard_valid,
                                                           // discard_value
);

    localparam int CAP = skv_pkg::CAPACITY;

    skv_pkg::t_fsm                      r_state, n_state;
    logic [skv_pkg::CMD_W-1:0]          r_cmd;
    logic [skv_pkg::KEY_W-1:0]          r_key;
    logic [skv_pkg::VALUE_BITS-1:0]     r_val;
    logic [skv_pkg::RANK_W-1:0]         r_rank;
    logic [skv_pkg::CNT_W-1:0]          r_count, n_count;
    logic                               r_discard_en;

    logic                               r_out_valid;
    skv_pkg::t_status                   r_out_status, n_out_status;
    logic [skv_pkg::OUT_VAL_W-1:0]      r_out_vout, n_out_vout;
    logic                               r_out_dvld, n_out_dvld;
    logic [skv_pkg::OUT_VAL_W-1:0]      r_out_dval, n_out_dval;

    skv_pkg::t_slot_ctl                 w_ctl;
    skv_pkg::t_slot_ent                 w_ent   [CAP];
    skv_pkg::t_slot_ent                 w_left  [CAP];
    skv_pkg::t_slot_ent                 w_right [CAP];
    logic [CAP-1:0]                     w_eq;
    logic [CAP-1:0]                     w_occ;
    logic [skv_pkg::VALUE_BITS-1:0]     w_sel_val [CAP];
    logic [skv_pkg::VALUE_BITS-1:0]     w_pick;

    logic                               w_accept;
    logic                               w_out_free;
    logic                               w_finish;
    logic                               w_found;
    logic                               w_full;
    logic                               w_empty;
    logic                               w_rank_oor;
    logic                               w_do_insert;
    logic                               w_do_remove;
    logic                               w_shift_all;

    assign o_cfg_ready = 1'b1;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_finish      = (r_state == skv_pkg::FSM_EXE) && w_out_free;
    assign s_axis_tready = (r_state == skv_pkg::FSM_IDLE) || w_finish;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        case (r_state)
            skv_pkg::FSM_IDLE: begin
                n_state = w_accept ? skv_pkg::FSM_CMP : skv_pkg::FSM_IDLE;
            end
            skv_pkg::FSM_CMP: begin
                n_state = skv_pkg::FSM_EXE;
            end
            skv_pkg::FSM_EXE: begin
                if (!w_out_free) begin
                    n_state = skv_pkg::FSM_EXE;
                end else if (w_accept) begin
                    n_state = skv_pkg::FSM_CMP;
                end else begin
                    n_state = skv_pkg::FSM_IDLE;
                end
            end
            default: begin
                n_state = skv_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= skv_pkg::FSM_IDLE;
            r_count      <= '0;
            r_discard_en <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_valid) begin
                r_discard_en <= i_cfg_data;
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= s_axis_tdata[skv_pkg::S_CMD_LSB +: skv_pkg::CMD_W];
            r_key  <= s_axis_tdata[skv_pkg::S_KEY_LSB +: skv_pkg::KEY_W];
            r_val  <= skv_pkg::VALUE_BITS'(s_axis_tdata[skv_pkg::S_VAL_LSB +: skv_pkg::IN_VAL_W]);
            r_rank <= s_axis_tdata[skv_pkg::S_RANK_LSB +: skv_pkg::RANK_W];
        end
        if (w_finish) begin
            r_out_status <= n_out_status;
            r_out_vout   <= n_out_vout;
            r_out_dvld   <= n_out_dvld;
            r_out_dval   <= n_out_dval;
        end
    end

    // slot row
    genvar gi;
    generate
        for (gi = 0; gi < CAP; gi++) begin : g_slot
            if (gi == 0) begin : g_first
                assign w_left[gi] = '{occ: 1'b0, lt: 1'b1, key: '0, value: '0};
            end else begin : g_mid_l
                assign w_left[gi] = w_ent[gi-1];
            end
            if (gi == CAP - 1) begin : g_last
                assign w_right[gi] = '0;
            end else begin : g_mid_r
                assign w_right[gi] = w_ent[gi+1];
            end

            skv_slot u_slot (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_idx     (skv_pkg::IDX_W'(gi)),
                .i_ctl     (w_ctl),
                .i_left    (w_left[gi]),
                .i_right   (w_right[gi]),
                .o_ent     (w_ent[gi]),
                .o_eq      (w_eq[gi]),
                .o_sel_val (w_sel_val[gi])
            );

            assign w_occ[gi] = w_ent[gi].occ;
        end
    endgenerate

    always_comb begin
        w_pick = '0;
        for (int i = 0; i < CAP; i++) begin
            w_pick = w_pick | w_sel_val[i];
        end
    end

    assign w_found    = |w_eq;
    assign w_full     = (r_count == skv_pkg::CNT_W'(CAP));
    assign w_empty    = (r_count == '0);
    assign w_rank_oor = (skv_pkg::POS_W'(r_rank) >= skv_pkg::POS_W'(r_count));

    always_comb begin
        n_out_status = skv_pkg::ST_OK;
        n_out_vout   = '0;
        n_out_dvld   = 1'b0;
        w_do_insert  = 1'b0;
        w_do_remove  = 1'b0;
        w_shift_all  = 1'b0;
        case (r_cmd)
            skv_pkg::CMD_INSERT: begin
                if (r_key == skv_pkg::KEY_RESERVED) begin
                    n_out_status = skv_pkg::ST_BAD_KEY;
                end else if (w_found) begin
                    n_out_status = skv_pkg::ST_DUPLICATE;
                end else if (w_full) begin
                    n_out_status = skv_pkg::ST_FULL;
                end else begin
                    w_do_insert = 1'b1;
                end
            end
            skv_pkg::CMD_REMOVE: begin
                if (r_key == skv_pkg::KEY_RESERVED || !w_found) begin
                    n_out_status = skv_pkg::ST_NOT_FOUND;
                end else begin
                    w_do_remove = 1'b1;
                    n_out_dvld  = 1'b1;
                end
            end
            skv_pkg::CMD_LOOKUP: begin
                if (r_key == skv_pkg::KEY_RESERVED || !w_found) begin
                    n_out_status = skv_pkg::ST_NOT_FOUND;
                end else begin
                    n_out_vout = skv_pkg::OUT_VAL_W'(w_pick);
                end
            end
            skv_pkg::CMD_RANK: begin
                if (w_rank_oor) begin
                    n_out_status = skv_pkg::ST_RANK_OOR;
                end else begin
                    n_out_vout = skv_pkg::OUT_VAL_W'(w_pick);
                end
            end
            skv_pkg::CMD_PEEK: begin
                if (w_empty) begin
                    n_out_status = skv_pkg::ST_EMPTY;
                end else begin
                    n_out_vout = skv_pkg::OUT_VAL_W'(w_pick);
                end
            end
            skv_pkg::CMD_POP: begin
                if (w_empty) begin
                    n_out_status = skv_pkg::ST_EMPTY;
                end else begin
                    w_do_remove = 1'b1;
                    w_shift_all = 1'b1;
                    n_out_dvld  = 1'b1;
                end
            end
            default: begin
                n_out_status = skv_pkg::ST_OK;
            end
        endcase
        n_out_dvld = n_out_dvld & r_discard_en;
        n_out_dval = n_out_dvld ? skv_pkg::OUT_VAL_W'(w_pick) : '0;
    end

    always_comb begin
        n_count = r_count;
        if (w_finish && w_do_insert) begin
            n_count = r_count + skv_pkg::CNT_W'(1);
        end else if (w_finish && w_do_remove) begin
            n_count = r_count - skv_pkg::CNT_W'(1);
        end
    end

    assign w_ctl.compare   = (r_state == skv_pkg::FSM_CMP);
    assign w_ctl.insert    = w_finish && w_do_insert;
    assign w_ctl.remove    = w_finish && w_do_remove;
    assign w_ctl.shift_all = w_shift_all;
    assign w_ctl.cmd       = r_cmd;
    assign w_ctl.key       = r_key;
    assign w_ctl.value     = r_val;
    assign w_ctl.rank      = r_rank;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = skv_pkg::M_DATA_W'({r_out_dval,
                                               r_out_dvld,
                                               skv_pkg::CNT_OUT_W'(r_count),
                                               r_out_vout,
                                               r_out_status});

    // occupied slots always form a contiguous run from slot zero
    a_occ_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_occ + CAP'(1)) & w_occ) == '0)
        else $error("occupied slots not contiguous");

    a_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        skv_pkg::CNT_W'($countones(w_occ)) == r_count)
        else $error("entry count disagrees with occupied slots");

    a_accept_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == skv_pkg::FSM_CMP))
        else $error("accepted beat did not start a compare pass");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == skv_pkg::FSM_EXE))
        else $error("result beat raised outside the shift pass");

    a_single_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctl.insert && w_ctl.remove) && !(w_ctl.compare && (w_ctl.insert || w_ctl.remove)))
        else $error("slot row driven with conflicting operations");

endmodule
